[src/ceau_pkg.sv]
// Shared types and addressing-mode codes for the CPU effective address unit.
`timescale 1ns / 1ps

package ceau_pkg;

  // Command codes: addressing modes, then the pointer data return
  localparam logic [4:0] MODE_IMP     = 5'd0;
  localparam logic [4:0] MODE_ACC     = 5'd1;
  localparam logic [4:0] MODE_INTR    = 5'd2;
  localparam logic [4:0] MODE_IMM_8   = 5'd3;
  localparam logic [4:0] MODE_IMM_M   = 5'd4;
  localparam logic [4:0] MODE_IMM_X   = 5'd5;
  localparam logic [4:0] MODE_ABS     = 5'd6;
  localparam logic [4:0] MODE_ABI     = 5'd7;
  localparam logic [4:0] MODE_ABX     = 5'd8;
  localparam logic [4:0] MODE_ABY     = 5'd9;
  localparam logic [4:0] MODE_ABIX    = 5'd10;
  localparam logic [4:0] MODE_ABL     = 5'd11;
  localparam logic [4:0] MODE_ABIL    = 5'd12;
  localparam logic [4:0] MODE_ALX     = 5'd13;
  localparam logic [4:0] MODE_DP      = 5'd14;
  localparam logic [4:0] MODE_DPX     = 5'd15;
  localparam logic [4:0] MODE_DPY     = 5'd16;
  localparam logic [4:0] MODE_DPI     = 5'd17;
  localparam logic [4:0] MODE_DPIX    = 5'd18;
  localparam logic [4:0] MODE_DPIY    = 5'd19;
  localparam logic [4:0] MODE_DPIL    = 5'd20;
  localparam logic [4:0] MODE_DPILY   = 5'd21;
  localparam logic [4:0] MODE_SR      = 5'd22;
  localparam logic [4:0] MODE_SRIY    = 5'd23;
  localparam logic [4:0] MODE_REL     = 5'd24;
  localparam logic [4:0] MODE_RELL    = 5'd25;
  localparam logic [4:0] MODE_PTR_RET = 5'd26;

  // Address command payload
  typedef struct packed {
    logic [4:0]  command;
    logic [15:0] prog_counter;
    logic [7:0]  prog_bank;
    logic [15:0] direct_page;
    logic [15:0] stack_pointer;
    logic [15:0] index_x;
    logic [15:0] index_y;
    logic        emulation;
    logic        accum_narrow;
    logic        index_narrow;
    logic [23:0] data_bytes;
  } cmd_t;

  // Address result payload
  typedef struct packed {
    logic [23:0] eff_addr;
    logic [15:0] next_counter;
    logic [15:0] pointer_address;
    logic        pointer_long;
    logic        needs_pointer;
    logic        page_cross;
    logic        done_res;
  } res_t;

endpackage

[src/ceau_cmd_if.sv]
// Valid/ready channel carrying address command transactions.
`timescale 1ns / 1ps

interface ceau_cmd_if import ceau_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/ceau_res_if.sv]
// Valid/ready channel carrying address result transactions.
`timescale 1ns / 1ps

interface ceau_res_if import ceau_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/cpu_effective_address_unit.sv]
// Top level of the CPU effective address unit: input register, address logic, result register.
`timescale 1ns / 1ps

// Computes the effective address, next program counter and page-cross flag for
// every 65C816 addressing mode. Each command transaction lands in an input
// register and its result in a result register, so a result reaches res only
// after passing through both registers; one command is taken every cycle as
// long as the result side keeps taking results; a stall on the result side
// backs up through both registers to cmd.ready. Indirect modes return a bank-0
// pointer address with needs_pointer set; the caller fetches two or three bytes
// (pointer_long) and sends them back as a pointer return command, which yields
// the final address with any pending Y post-index added. Any addressing mode
// sent in between drops the pending pointer (an indirect one replaces it);
// unused command codes leave it.

module cpu_effective_address_unit import ceau_pkg::*; (
  input  logic clk,
  input  logic rst,
  ceau_cmd_if.sink   cmd,
  ceau_res_if.source res
);

  // Direct page address with emulation-mode page wrap
  function automatic logic [15:0] dp_addr(input logic [15:0] dp, input logic [7:0] off,
                                          input logic [15:0] idx, input logic emu);
    logic [7:0] low;
    low = off + idx[7:0];
    if (emu && (dp[7:0] == 8'h00)) begin
      return {dp[15:8], low};
    end
    return dp + {8'h00, off} + idx;
  endfunction

  // Pipeline registers
  logic        a_valid;
  cmd_t        a_data;
  logic        b_valid;
  res_t        b_data;
  logic        b_load;

  // Pointer pending across transactions
  logic        pending_valid;
  logic        pending_long;
  logic [15:0] pending_offset;
  logic        pending_valid_next;
  logic        pending_long_next;
  logic [15:0] pending_offset_next;

  res_t        res_next;

  assign b_load    = a_valid && (!b_valid || res.ready);
  assign cmd.ready = !a_valid || !b_valid || res.ready;
  assign res.valid = b_valid;
  assign res.data  = b_data;

  // Address generation from the input register
  always_comb begin
    logic        mn;
    logic        xn;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] pc;
    logic [23:0] dat;
    logic [15:0] d16;
    logic [7:0]  d8;
    logic [15:0] poff;
    logic [15:0] dp0;
    logic [23:0] ea;

    mn  = a_data.accum_narrow | a_data.emulation;
    xn  = a_data.index_narrow | a_data.emulation;
    x   = xn ? {8'h00, a_data.index_x[7:0]} : a_data.index_x;
    y   = xn ? {8'h00, a_data.index_y[7:0]} : a_data.index_y;
    pc  = a_data.prog_counter;
    dat = a_data.data_bytes;
    d16 = dat[15:0];
    d8  = dat[7:0];
    dp0 = dp_addr(a_data.direct_page, d8, 16'h0000, a_data.emulation);
    poff = 16'h0000;
    ea   = 24'h000000;

    res_next = '0;
    res_next.next_counter = pc;
    res_next.done_res     = 1'b1;

    pending_valid_next  = pending_valid;
    pending_long_next   = pending_long;
    pending_offset_next = pending_offset;

    unique case (a_data.command) inside
      MODE_IMP, MODE_ACC: begin
      end
      MODE_INTR: res_next.next_counter = pc + 16'd1;
      MODE_IMM_8: begin
        ea = {a_data.prog_bank, pc};
        res_next.next_counter = pc + 16'd1;
      end
      MODE_IMM_M: begin
        ea = {a_data.prog_bank, pc};
        res_next.next_counter = pc + (mn ? 16'd1 : 16'd2);
      end
      MODE_IMM_X: begin
        ea = {a_data.prog_bank, pc};
        res_next.next_counter = pc + (xn ? 16'd1 : 16'd2);
      end
      MODE_ABS: begin
        ea = {8'h00, d16};
        res_next.next_counter = pc + 16'd2;
      end
      MODE_ABI: begin
        res_next.needs_pointer   = 1'b1;
        res_next.pointer_address = d16;
        res_next.next_counter    = pc + 16'd2;
      end
      MODE_ABX, MODE_ABY: begin
        ea = {8'h00, d16} + {8'h00, (a_data.command == MODE_ABX) ? x : y};
        res_next.page_cross   = (d16[15:8] != ea[15:8]);
        res_next.next_counter = pc + 16'd2;
      end
      MODE_ABIX: begin
        res_next.needs_pointer   = 1'b1;
        res_next.pointer_address = d16 + x;
        res_next.next_counter    = pc + 16'd2;
      end
      MODE_ABL: begin
        ea = dat;
        res_next.next_counter = pc + 16'd3;
      end
      MODE_ABIL: begin
        res_next.needs_pointer   = 1'b1;
        res_next.pointer_long    = 1'b1;
        res_next.pointer_address = d16;
        res_next.next_counter    = pc + 16'd2;
      end
      MODE_ALX: begin
        ea = dat + {8'h00, x};
        res_next.next_counter = pc + 16'd3;
      end
      MODE_DP: begin
        ea = {8'h00, dp0};
        res_next.next_counter = pc + 16'd1;
      end
      MODE_DPX: begin
        ea = {8'h00, dp_addr(a_data.direct_page, d8, x, a_data.emulation)};
        res_next.next_counter = pc + 16'd1;
      end
      MODE_DPY: begin
        ea = {8'h00, dp_addr(a_data.direct_page, d8, y, a_data.emulation)};
        res_next.next_counter = pc + 16'd1;
      end
      MODE_DPI: begin
        res_next.needs_pointer   = 1'b1;
        res_next.pointer_address = dp0;
        res_next.next_counter    = pc + 16'd1;
      end
      MODE_DPIX: begin
        res_next.needs_pointer   = 1'b1;
        res_next.pointer_address = dp_addr(a_data.direct_page, d8, x, a_data.emulation);
        res_next.next_counter    = pc + 16'd1;
      end
      MODE_DPIY: begin
        res_next.needs_pointer   = 1'b1;
        res_next.pointer_address = dp0;
        poff                     = y;
        res_next.next_counter    = pc + 16'd1;
      end
      MODE_DPIL: begin
        res_next.needs_pointer   = 1'b1;
        res_next.pointer_long    = 1'b1;
        res_next.pointer_address = dp0;
        res_next.next_counter    = pc + 16'd1;
      end
      MODE_DPILY: begin
        res_next.needs_pointer   = 1'b1;
        res_next.pointer_long    = 1'b1;
        res_next.pointer_address = dp0;
        poff                     = y;
        res_next.next_counter    = pc + 16'd1;
      end
      MODE_SR: begin
        ea = {8'h00, a_data.stack_pointer + {8'h00, d8}};
        res_next.next_counter = pc + 16'd1;
      end
      MODE_SRIY: begin
        res_next.needs_pointer   = 1'b1;
        res_next.pointer_address = a_data.stack_pointer + {8'h00, d8};
        poff                     = y;
        res_next.next_counter    = pc + 16'd1;
      end
      MODE_REL: begin
        ea = {8'h00, pc + 16'd1 + {{8{d8[7]}}, d8}};
        res_next.next_counter = pc + 16'd1;
      end
      MODE_RELL: begin
        ea = {8'h00, pc + 16'd2 + d16};
        res_next.next_counter = pc + 16'd2;
      end
      MODE_PTR_RET: begin
        if (pending_valid) begin
          ea = (pending_long ? dat : {8'h00, d16}) + {8'h00, pending_offset};
        end else begin
          res_next.done_res = 1'b0;
        end
        pending_valid_next  = 1'b0;
        pending_long_next   = 1'b0;
        pending_offset_next = 16'h0000;
      end
      default: res_next.done_res = 1'b0;
    endcase

    // Address modes either open a pointer fetch or drop any pending one
    if (a_data.command <= MODE_RELL) begin
      if (res_next.needs_pointer) begin
        res_next.done_res   = 1'b0;
        ea                  = 24'h000000;
        pending_valid_next  = 1'b1;
        pending_long_next   = res_next.pointer_long;
        pending_offset_next = poff;
      end else begin
        pending_valid_next  = 1'b0;
        pending_long_next   = 1'b0;
        pending_offset_next = 16'h0000;
      end
    end

    res_next.eff_addr = ea;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (cmd.ready) begin
      a_valid <= cmd.valid;
    end
    if (cmd.ready && cmd.valid) begin
      a_data <= cmd.data;
    end
  end

  // Result register and pending pointer state
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid        <= 1'b0;
      pending_valid  <= 1'b0;
      pending_long   <= 1'b0;
      pending_offset <= 16'h0000;
    end else begin
      if (b_load) begin
        b_valid        <= 1'b1;
        pending_valid  <= pending_valid_next;
        pending_long   <= pending_long_next;
        pending_offset <= pending_offset_next;
      end else if (res.ready) begin
        b_valid <= 1'b0;
      end
    end
    if (b_load) begin
      b_data <= res_next;
    end
  end

  // Checks
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !cmd.ready |-> (a_valid && b_valid && !res.ready))
    else $error("command side stalled without a full pipeline");

  a_ptr_opens: assert property (@(posedge clk) disable iff (rst)
    (b_load && res_next.needs_pointer) |=> pending_valid)
    else $error("indirect mode did not leave a pending pointer");

  a_ptr_closes: assert property (@(posedge clk) disable iff (rst)
    (b_load && (a_data.command == MODE_PTR_RET)) |=> !pending_valid)
    else $error("pointer return left a pending pointer");

  a_ptr_not_done: assert property (@(posedge clk) disable iff (rst)
    (b_load && res_next.needs_pointer) |=> !b_data.done_res)
    else $error("pointer request marked as final address");

endmodule
